FILE: rtl/fptm_pkg.sv
// Package with shared constants, types and a helper function of the frame timing monitor.
`default_nettype none
package fptm_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TIME_W      = 64;
  localparam int MAXREG_W    = 63;
  localparam int OUT_W       = 32;
  localparam int DIV_CNT_W   = $clog2(TIME_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_ANC_WAIT,
    ST_CUR_GO,
    ST_CUR_WAIT,
    ST_PREV_GO,
    ST_PREV_WAIT,
    ST_DONE
  } fptm_state_t;

  typedef enum logic [1:0] {
    DIV_ANCHOR,
    DIV_CUR,
    DIV_PREV
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     upd_reg;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_anchor;
    logic     take_cur;
    logic     take_prev;
    logic     commit;
  } fptm_cmd_t;

  typedef struct packed {
    logic vs_ok;
    logic need_anchor;
    logic last_pos;
    logic div_done;
  } fptm_stat_t;

  typedef struct packed {
    logic              neg;
    logic [TIME_W-1:0] mag;
  } slot_t;

  // Slot offset from a quotient and remainder; ge tells whether the time
  // lies at or after the anchor.
  function automatic slot_t to_slot(input logic ge, input logic [TIME_W-1:0] q,
                                    input logic [TIME_W-1:0] r);
    slot_t s;
    if (ge) begin
      s.mag = q + TIME_W'(r != '0);
      s.neg = 1'b0;
    end else begin
      s.mag = q;
      s.neg = (q != '0);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fptm_if.sv
// Valid/ready channel interfaces for frame records and statistics results.
`default_nettype none
interface fptm_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] target_time;
  logic signed [63:0] now_time;
  logic signed [63:0] observed_vsync;
  logic signed [63:0] vsync_period;

  modport source (output valid, target_time, now_time, observed_vsync, vsync_period,
                  input ready);
  modport sink (input valid, target_time, now_time, observed_vsync, vsync_period,
                output ready);
endinterface

interface fptm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] regression_count;
  logic [62:0] max_regression;
  logic [31:0] same_slot_count;
  logic [31:0] slot_regression_count;
  logic [31:0] max_queue_depth;

  modport source (output valid, regression_count, max_regression, same_slot_count,
                  slot_regression_count, max_queue_depth, input ready);
  modport sink (input valid, regression_count, max_regression, same_slot_count,
                slot_regression_count, max_queue_depth, output ready);
endinterface
`default_nettype wire

FILE: rtl/fptm_div.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
`default_nettype none
module fptm_div import fptm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic [TIME_W-1:0]      quotient,
  output logic [TIME_W-1:0]      remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    quo_r, quo_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    dsr_r, dsr_nxt;
  logic [TIME_W:0]      trial;

  assign trial = {rem_r, quo_r[TIME_W-1]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[TIME_W]) begin
        rem_nxt = trial[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[TIME_W-2:0], quo_r[TIME_W-1]};
        quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: rtl/fptm_dp.sv
// Datapath: record registers, anchor and slot arithmetic, statistics and result register.
`default_nettype none
module fptm_dp import fptm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fptm_cmd_t                cmd,
  output fptm_stat_t                    stat,
  input  wire logic signed [TIME_W-1:0] target_time,
  input  wire logic signed [TIME_W-1:0] now_time,
  input  wire logic signed [TIME_W-1:0] observed_vsync,
  input  wire logic signed [TIME_W-1:0] vsync_period,
  output logic [OUT_W-1:0]              regression_count,
  output logic [MAXREG_W-1:0]           max_regression,
  output logic [OUT_W-1:0]              same_slot_count,
  output logic [OUT_W-1:0]              slot_regression_count,
  output logic [OUT_W-1:0]              max_queue_depth
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Record and working registers.
  logic signed [TIME_W-1:0] tgt_r, now_r, vs_r, per_r, anchor_r;
  slot_t                    cur_r;
  // Statistics.
  logic signed [TIME_W-1:0] last_r, last_nxt;
  logic [COUNT_WIDTH-1:0]   regs_r, regs_nxt;
  logic [MAXREG_W-1:0]      big_r, big_nxt;
  logic [COUNT_WIDTH-1:0]   same_r, same_nxt;
  logic [COUNT_WIDTH-1:0]   sreg_r, sreg_nxt;
  logic [COUNT_WIDTH-1:0]   deep_r, deep_nxt;
  // Result register.
  logic [OUT_W-1:0]         o_regs_r, o_same_r, o_sreg_r, o_deep_r;
  logic [MAXREG_W-1:0]      o_big_r;

  logic                     last_pos, cur_ge, prev_ge, is_reg;
  logic [TIME_W:0]          step;
  logic [MAXREG_W-1:0]      step_sat;
  logic [TIME_W-1:0]        dividend, quo, rem;
  logic                     div_done;
  slot_t                    cur_slot, prev_slot;
  logic                     slot_eq, slot_lt;
  logic [COUNT_WIDTH-1:0]   depth;

  assign last_pos = !last_r[TIME_W-1] && (last_r != '0);
  assign cur_ge   = tgt_r >= anchor_r;
  assign prev_ge  = last_r >= anchor_r;
  assign is_reg   = last_pos && (tgt_r < last_r);

  assign stat.vs_ok = !vs_r[TIME_W-1] && (vs_r != '0) && !per_r[TIME_W-1] && (per_r != '0);
  assign stat.need_anchor = now_r > vs_r;
  assign stat.last_pos    = last_pos;
  assign stat.div_done    = div_done;

  assign step     = {last_r[TIME_W-1], last_r} - {tgt_r[TIME_W-1], tgt_r};
  assign step_sat = (step[TIME_W:MAXREG_W] != '0) ? '1 : step[MAXREG_W-1:0];

  always_comb begin
    case (cmd.div_sel)
      DIV_ANCHOR: dividend = now_r - vs_r;
      DIV_CUR:    dividend = cur_ge ? (tgt_r - anchor_r) : (anchor_r - tgt_r);
      DIV_PREV:   dividend = prev_ge ? (last_r - anchor_r) : (anchor_r - last_r);
      default:    dividend = '0;
    endcase
  end

  fptm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (per_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign cur_slot  = to_slot(cur_ge, quo, rem);
  assign prev_slot = to_slot(prev_ge, quo, rem);

  // Ordering of the current slot against the previous one.
  always_comb begin
    slot_eq = (cur_r.neg == prev_slot.neg) && (cur_r.mag == prev_slot.mag);
    if (cur_r.neg != prev_slot.neg) begin
      slot_lt = cur_r.neg;
    end else if (cur_r.neg) begin
      slot_lt = cur_r.mag > prev_slot.mag;
    end else begin
      slot_lt = cur_r.mag < prev_slot.mag;
    end
  end

  assign depth = (cur_slot.mag > TIME_W'(COUNT_MAX)) ? COUNT_MAX
                                                     : cur_slot.mag[COUNT_WIDTH-1:0];

  always_comb begin
    last_nxt = last_r;
    regs_nxt = regs_r;
    big_nxt  = big_r;
    same_nxt = same_r;
    sreg_nxt = sreg_r;
    deep_nxt = deep_r;
    if (cmd.upd_reg && is_reg) begin
      regs_nxt = (regs_r == COUNT_MAX) ? regs_r : regs_r + 1'b1;
      if (step_sat > big_r) begin
        big_nxt = step_sat;
      end
    end
    if (cmd.take_cur && !cur_slot.neg && (depth > deep_r)) begin
      deep_nxt = depth;
    end
    if (cmd.take_prev) begin
      if (slot_eq) begin
        same_nxt = (same_r == COUNT_MAX) ? same_r : same_r + 1'b1;
      end else if (slot_lt) begin
        sreg_nxt = (sreg_r == COUNT_MAX) ? sreg_r : sreg_r + 1'b1;
      end
    end
    if (cmd.commit) begin
      last_nxt = tgt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      regs_r <= '0;
      big_r  <= '0;
      same_r <= '0;
      sreg_r <= '0;
      deep_r <= '0;
    end else begin
      last_r <= last_nxt;
      regs_r <= regs_nxt;
      big_r  <= big_nxt;
      same_r <= same_nxt;
      sreg_r <= sreg_nxt;
      deep_r <= deep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt_r    <= target_time;
      now_r    <= now_time;
      vs_r     <= observed_vsync;
      per_r    <= vsync_period;
      anchor_r <= observed_vsync;
    end else if (cmd.take_anchor) begin
      anchor_r <= now_r - rem;
    end
    if (cmd.take_cur) begin
      cur_r <= cur_slot;
    end
    if (cmd.commit) begin
      o_regs_r <= OUT_W'(regs_r);
      o_big_r  <= big_r;
      o_same_r <= OUT_W'(same_r);
      o_sreg_r <= OUT_W'(sreg_r);
      o_deep_r <= OUT_W'(deep_r);
    end
  end

  assign regression_count      = o_regs_r;
  assign max_regression        = o_big_r;
  assign same_slot_count       = o_same_r;
  assign slot_regression_count = o_sreg_r;
  assign max_queue_depth       = o_deep_r;

endmodule
`default_nettype wire

FILE: rtl/fptm_ctrl.sv
// Controller state machine sequencing the regression check and the three divisions.
`default_nettype none
module fptm_ctrl import fptm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire fptm_stat_t stat,
  output fptm_cmd_t       cmd
);

  fptm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_REG;
        end
      end
      ST_REG: begin
        if (!stat.vs_ok) begin
          state_nxt = ST_DONE;
        end else if (stat.need_anchor) begin
          state_nxt = ST_ANC_WAIT;
        end else begin
          state_nxt = ST_CUR_GO;
        end
      end
      ST_ANC_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_CUR_GO;
        end
      end
      ST_CUR_GO: state_nxt = ST_CUR_WAIT;
      ST_CUR_WAIT: begin
        if (stat.div_done) begin
          state_nxt = stat.last_pos ? ST_PREV_GO : ST_DONE;
        end
      end
      ST_PREV_GO: state_nxt = ST_PREV_WAIT;
      ST_PREV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_REG: begin
        cmd.upd_reg   = 1'b1;
        cmd.div_start = stat.vs_ok && stat.need_anchor;
        cmd.div_sel   = DIV_ANCHOR;
      end
      ST_ANC_WAIT: begin
        cmd.div_sel     = DIV_ANCHOR;
        cmd.take_anchor = stat.div_done;
      end
      ST_CUR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CUR;
      end
      ST_CUR_WAIT: begin
        cmd.div_sel  = DIV_CUR;
        cmd.take_cur = stat.div_done;
      end
      ST_PREV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PREV;
      end
      ST_PREV_WAIT: begin
        cmd.div_sel   = DIV_PREV;
        cmd.take_prev = stat.div_done;
      end
      ST_DONE: cmd.commit = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/frame_present_timing_monitor.sv
// Top level of the frame presentation timing monitor.
//
//   Channel   Direction  Handshake     Payload
//   in_chan   sink       valid/ready   target_time, now_time, observed_vsync, vsync_period
//   out_chan  source     valid/ready   regression_count, max_regression, same_slot_count,
//                                      slot_regression_count, max_queue_depth
//
// One request is processed at a time. After acceptance, state ST_REG applies
// the regression check; then a shared restoring divider runs up to three times:
// once for the vsync anchor, once for the slot of the new target and once for
// the slot of the last target.
// Reset is synchronous and active low; it clears all statistics and the last
// target. The result sits in an output register, so a new request is taken
// while an earlier result still waits; only the hand-over of the next result
// waits on out_chan.ready.
`default_nettype none
module frame_present_timing_monitor import fptm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fptm_in_if.sink   in_chan,
  fptm_out_if.source out_chan
);

  fptm_cmd_t  cmd;
  fptm_stat_t stat;

  // The controller owns the handshakes and the sequence of steps.
  fptm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the record, the statistics and the result register.
  fptm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .target_time           (in_chan.target_time),
    .now_time              (in_chan.now_time),
    .observed_vsync        (in_chan.observed_vsync),
    .vsync_period          (in_chan.vsync_period),
    .regression_count      (out_chan.regression_count),
    .max_regression        (out_chan.max_regression),
    .same_slot_count       (out_chan.same_slot_count),
    .slot_regression_count (out_chan.slot_regression_count),
    .max_queue_depth       (out_chan.max_queue_depth)
  );

endmodule
`default_nettype wire

FILE: rtl/fptm_chk.sv
// Port-level checker for the frame timing monitor, bound to the top level.
`default_nettype none
module fptm_chk import fptm_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [MAXREG_W-1:0] max_regression
);

  logic                in_acc, out_acc;
  logic [1:0]          pend_r, pend_nxt;
  logic [MAXREG_W-1:0] seen_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        seen_r <= max_regression;
      end
    end
  end

  // A result never shows up without a request behind it.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result without a pending request");

  // At most one request in work and one result waiting.
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3))
    else $error("too many requests outstanding");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while busy");

  // The largest regression never shrinks between results.
  a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (max_regression >= seen_r))
    else $error("max regression decreased");

  // A waiting result stays valid until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before hand-over");

endmodule

bind frame_present_timing_monitor fptm_chk u_fptm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .max_regression (out_chan.max_regression)
);
`default_nettype wire
